/* rtl/rtp_header_length_parser_defines.svh */
// ---------------------------------------------------------------------------
// RTP header length parser assertion macros
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef RTP_HEADER_LENGTH_PARSER_DEFINES_SVH
`define RTP_HEADER_LENGTH_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rtp header length parser: invariant violated");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtp header length parser: implication violated");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtp header length parser: next-cycle check violated");

`else

`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/rtphl_pkg.sv */
// ---------------------------------------------------------------------------
// RTP header length parser package
// Shared constants, status codes and pipeline record type.
// ---------------------------------------------------------------------------
package rtphl_pkg;

   localparam int unsigned MAX_PACKET_BYTES_DEFAULT = 65535;
   localparam int unsigned MIN_HEADER_BYTES         = 12;
   localparam int unsigned EXT_LEN_OFFSET           = 14;
   localparam int unsigned HDR_W                    = 19;
   localparam int unsigned PAYLOAD_W                = 16;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_HDR   = 2'd2,
      STATUS_LONG  = 2'd3
   } status_type;

   typedef struct packed {
      logic             short_pkt;
      logic             long_pkt;
      logic [HDR_W-1:0] len;
      logic [HDR_W-1:0] hdr;
      logic [3:0]       csrc;
      logic             ext;
      logic             padf;
      logic [7:0]       pad_byte;
   } final_type;

endpackage

/* rtl/rtp_header_length_parser.sv */
// Result path: the final byte's stage loads when that byte is accepted, and the result register
// loads from that stage once the output is not stalled; the result is then held until taken.
// Throughput: one byte per cycle; req_stall rises only while both the final-byte
// stage and the result register hold items and rsp_stall is high.
// Reset: synchronous, active high; clears packet state and both valid flags.
// ---------------------------------------------------------------------------
// RTP header length parser
// Tracks one RTP packet byte by byte, captures CC, X and P from byte 0 and the
// extension length, and on the final byte reports header, payload, padding
// sizes and a status.
// ---------------------------------------------------------------------------
`include "rtp_header_length_parser_defines.svh"

module rtp_header_length_parser #(
   parameter int unsigned MAX_PACKET_BYTES = rtphl_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_padding_rejected,
   output logic [18:0] rsp_header_size,
   output logic [15:0] rsp_payload_size,
   output logic [7:0]  rsp_padding_size,
   output logic [3:0]  rsp_csrc_total,
   output logic        rsp_has_extension
);

   localparam int unsigned HDR_W = rtphl_pkg::HDR_W;
   localparam int unsigned PAY_W = rtphl_pkg::PAYLOAD_W;
   localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 3);
   localparam int unsigned CMP_W = POS_W + 7;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
   localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_PACKET_BYTES + 1);
   localparam logic [POS_W-1:0] POS_MIN = POS_W'(rtphl_pkg::MIN_HEADER_BYTES);

   // packet state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       cc_ff, cc_in;
   logic             ext_ff, ext_in;
   logic             padf_ff, padf_in;
   logic [15:0]      ew_ff, ew_in;

   // final-byte stage and result register
   logic                  s1_valid_ff, s1_valid_in;
   rtphl_pkg::final_type  s1_ff, s1_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rtphl_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                  rsp_rej_ff, rsp_rej_in;
   logic [HDR_W-1:0]      rsp_hdr_ff, rsp_hdr_in;
   logic [PAY_W-1:0]      rsp_pay_ff, rsp_pay_in;
   logic [7:0]            rsp_pad_ff, rsp_pad_in;
   logic [3:0]            rsp_cc_ff;
   logic                  rsp_ext_ff;

   logic             accept, fin, out_en, first;
   logic [3:0]       cc_cur;
   logic             ext_cur, padf_cur;
   logic [6:0]       ext_at;
   logic [15:0]      ew_cur;
   logic [POS_W-1:0] len;
   logic             long_pkt;
   logic [HDR_W-1:0] hdr_cur, ext_bytes, rem;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_en;
   assign accept    = req_valid && !req_stall;
   assign fin       = accept && req_last_byte;

   // byte-level capture
   always_comb begin
      first    = (pos_ff == '0);
      cc_cur   = first ? req_data_byte[3:0] : cc_ff;
      ext_cur  = first ? req_data_byte[4]   : ext_ff;
      padf_cur = first ? req_data_byte[5]   : padf_ff;
      ext_at   = 7'(rtphl_pkg::EXT_LEN_OFFSET) + {1'b0, cc_cur, 2'b00};
      if (CMP_W'(pos_ff) == CMP_W'(ext_at)) begin
         ew_cur = {req_data_byte, ew_ff[7:0]};
      end else if (CMP_W'(pos_ff) == CMP_W'(ext_at) + CMP_W'(1)) begin
         ew_cur = {ew_ff[15:8], req_data_byte};
      end else begin
         ew_cur = ew_ff;
      end
      len       = pos_ff + POS_W'(1);
      long_pkt  = (len > POS_MAX);
      ext_bytes = ext_cur ? HDR_W'({(17'(ew_cur) + 17'd1), 2'b00}) : '0;
      hdr_cur   = HDR_W'(rtphl_pkg::MIN_HEADER_BYTES) + HDR_W'({cc_cur, 2'b00}) + ext_bytes;

      if (fin) begin
         pos_in  = '0;
         cc_in   = '0;
         ext_in  = 1'b0;
         padf_in = 1'b0;
         ew_in   = '0;
      end else if (accept) begin
         pos_in  = long_pkt ? POS_SAT : len;
         cc_in   = cc_cur;
         ext_in  = ext_cur;
         padf_in = padf_cur;
         ew_in   = ew_cur;
      end else begin
         pos_in  = pos_ff;
         cc_in   = cc_ff;
         ext_in  = ext_ff;
         padf_in = padf_ff;
         ew_in   = ew_ff;
      end

      s1_in.short_pkt = (len < POS_MIN);
      s1_in.long_pkt  = long_pkt;
      s1_in.len       = HDR_W'(len);
      s1_in.hdr       = hdr_cur;
      s1_in.csrc      = cc_cur;
      s1_in.ext       = ext_cur;
      s1_in.padf      = padf_cur;
      s1_in.pad_byte  = req_data_byte;

      s1_valid_in  = fin ? 1'b1 : (out_en ? 1'b0 : s1_valid_ff);
      rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;
   end

   // result evaluation
   always_comb begin
      rem           = s1_ff.len - s1_ff.hdr;
      rsp_status_in = rtphl_pkg::STATUS_OK;
      rsp_rej_in    = 1'b0;
      rsp_hdr_in    = s1_ff.hdr;
      rsp_pay_in    = '0;
      rsp_pad_in    = '0;
      priority if (s1_ff.short_pkt) begin
         rsp_status_in = rtphl_pkg::STATUS_SHORT;
         rsp_hdr_in    = '0;
      end else if (s1_ff.long_pkt) begin
         rsp_status_in = rtphl_pkg::STATUS_LONG;
      end else if (s1_ff.len < s1_ff.hdr) begin
         rsp_status_in = rtphl_pkg::STATUS_HDR;
      end else if (!s1_ff.padf) begin
         rsp_pay_in = PAY_W'(rem);
      end else if (HDR_W'(s1_ff.pad_byte) > rem) begin
         rsp_rej_in = 1'b1;
         rsp_pay_in = PAY_W'(rem);
      end else begin
         rsp_pad_in = s1_ff.pad_byte;
         rsp_pay_in = PAY_W'(rem - HDR_W'(s1_ff.pad_byte));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cc_ff        <= '0;
         ext_ff       <= 1'b0;
         padf_ff      <= 1'b0;
         ew_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         cc_ff        <= cc_in;
         ext_ff       <= ext_in;
         padf_ff      <= padf_in;
         ew_ff        <= ew_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         s1_ff <= s1_in;
      end
      if (out_en && s1_valid_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_rej_ff    <= rsp_rej_in;
         rsp_hdr_ff    <= rsp_hdr_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_pad_ff    <= rsp_pad_in;
         rsp_cc_ff     <= s1_ff.csrc;
         rsp_ext_ff    <= s1_ff.ext;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_padding_rejected = rsp_rej_ff;
   assign rsp_header_size      = rsp_hdr_ff;
   assign rsp_payload_size     = rsp_pay_ff;
   assign rsp_padding_size     = rsp_pad_ff;
   assign rsp_csrc_total       = rsp_cc_ff;
   assign rsp_has_extension    = rsp_ext_ff;

   `ASSERT_IMPLIES(a_err_no_payload, clock, reset, rsp_valid_ff && rsp_status_ff != rtphl_pkg::STATUS_OK, rsp_pay_ff == '0 && rsp_pad_ff == '0 && !rsp_rej_ff)
   `ASSERT_IMPLIES(a_reject_ok, clock, reset, rsp_valid_ff && rsp_rej_ff, rsp_status_ff == rtphl_pkg::STATUS_OK && rsp_pad_ff == '0)
   `ASSERT_NEXT(a_state_cleared, clock, reset, req_valid && !req_stall && req_last_byte, pos_ff == '0 && ew_ff == '0 && s1_valid_ff)
   `ASSERT_HOLDS(a_pos_saturates, clock, reset, pos_ff <= POS_SAT)

endmodule
